### rtl/psde_pkg.sv
// Shared constants and codes for the post-seismic deformation evaluator.
// No dependencies; every other file imports this package.
`default_nettype none
package psde_pkg;

    // model codes
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_LOG     = 3'd1;
    localparam logic [2:0] OP_EXP     = 3'd2;
    localparam logic [2:0] OP_LOG_EXP = 3'd3;
    localparam logic [2:0] OP_TWO_EXP = 3'd4;

    // ratio format: unsigned Q.30
    localparam int          QB    = 30;
    localparam logic [30:0] ONE_Q = 31'h4000_0000;
    localparam logic [29:0] LN2_Q = 30'd744261118;

    // quotient width of (dt << 30) / t
    localparam int DIV_Q_W = 32 + QB;

    // stage counts of the units
    localparam int DIV_LAT  = DIV_Q_W;
    localparam int LOG_LAT  = 38;
    localparam int EXP_LAT  = 46;
    localparam int TERM_LAT = 3;

    localparam logic signed [40:0] OUT_MAX = 41'sd549755813887;
    localparam logic signed [40:0] OUT_MIN = -41'sd549755813888;

endpackage
`default_nettype wire

### rtl/post_seismic_deformation_eval_unit.sv
// Top level of the post-seismic deformation evaluator: input stage, two dividers,
// log and exp units, term scaling and saturation. Depends on psde_pkg and all psde_* modules.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------------------
//  request   | start / busy       | operation, elapsed_years, amplitude_one,
//            |                    | relax_time_one, amplitude_two, relax_time_two
//  result    | done (one cycle)   | deformation_mm, zero_time_error, saturated
//
// A request is taken in every cycle; busy stays low. Results leave in order.
// The depth is set by the 62-stage divider and the 13-term exp series.
// The receiver cannot hold off done, so nothing in the pipeline ever stalls.
// Reset clears the valid bits only; data stages are free-running.
`default_nettype none
module post_seismic_deformation_eval_unit import psde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         operation,
    input  logic [31:0]        elapsed_years,
    input  logic signed [31:0] amplitude_one,
    input  logic [31:0]        relax_time_one,
    input  logic signed [31:0] amplitude_two,
    input  logic [31:0]        relax_time_two,
    output logic               done,
    output logic signed [39:0] deformation_mm,
    output logic               zero_time_error,
    output logic               saturated
);

    localparam int SIDE_LEN = DIV_LAT + EXP_LAT;
    localparam int LOG_PAD  = EXP_LAT - LOG_LAT;
    localparam int PIPE_LAT = 2 + DIV_LAT + EXP_LAT + TERM_LAT;

    typedef struct packed {
        logic               use_terms;
        logic               zerr;
        logic               log_one;
        logic               two;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
    } side_t;

    typedef struct packed {
        logic use_terms;
        logic zerr;
        logic two;
    } tail_t;

    logic               accept;
    side_t              in_side;
    logic               in_vld_reg;
    side_t              in_side_reg;
    logic [31:0]        in_dt_reg;
    logic [31:0]        in_t1_reg;
    logic [31:0]        in_t2_reg;

    logic [SIDE_LEN-1:0] side_vld_reg;
    side_t               side_reg [SIDE_LEN];
    logic [TERM_LAT-1:0] tail_vld_reg;
    tail_t               tail_reg [TERM_LAT];

    logic [DIV_Q_W-1:0] r1;
    logic [DIV_Q_W-1:0] r2;
    logic [34:0]        ln1;
    logic [30:0]        ex1;
    logic [30:0]        ex2;
    logic [34:0]        logd_reg [LOG_PAD];
    logic [34:0]        fac1;
    logic signed [38:0] term1;
    logic signed [38:0] term2;

    logic               done_reg;
    logic signed [39:0] def_reg;
    logic               zerr_reg;
    logic               sat_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // decode the model
    always_comb
    begin
        logic active;
        logic two;
        logic log_one;
        active  = 1'b0;
        two     = 1'b0;
        log_one = 1'b0;
        unique case (operation)
            OP_LOG:
            begin
                active  = 1'b1;
                log_one = 1'b1;
            end
            OP_EXP:
            begin
                active = 1'b1;
            end
            OP_LOG_EXP:
            begin
                active  = 1'b1;
                log_one = 1'b1;
                two     = 1'b1;
            end
            OP_TWO_EXP:
            begin
                active = 1'b1;
                two    = 1'b1;
            end
            default:
            begin
                active = 1'b0;
            end
        endcase
        in_side.zerr      = active && (relax_time_one == '0 ||
                                       (two && relax_time_two == '0));
        in_side.use_terms = active && !in_side.zerr;
        in_side.log_one   = log_one;
        in_side.two       = two;
        in_side.a1        = amplitude_one;
        in_side.a2        = amplitude_two;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            side_vld_reg <= '0;
            tail_vld_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_vld_reg   <= accept;
            side_vld_reg <= {side_vld_reg[SIDE_LEN-2:0], in_vld_reg};
            tail_vld_reg <= {tail_vld_reg[TERM_LAT-2:0], side_vld_reg[SIDE_LEN-1]};
            done_reg     <= tail_vld_reg[TERM_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        in_side_reg <= in_side;
        in_dt_reg   <= elapsed_years;
        in_t1_reg   <= relax_time_one;
        in_t2_reg   <= relax_time_two;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side_reg;
        for (int i = 1; i < SIDE_LEN; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
        tail_reg[0] <= '{use_terms: side_reg[SIDE_LEN-1].use_terms,
                         zerr:      side_reg[SIDE_LEN-1].zerr,
                         two:       side_reg[SIDE_LEN-1].two};
        for (int i = 1; i < TERM_LAT; i++)
        begin
            tail_reg[i] <= tail_reg[i-1];
        end
        logd_reg[0] <= ln1;
        for (int i = 1; i < LOG_PAD; i++)
        begin
            logd_reg[i] <= logd_reg[i-1];
        end
    end

    psde_div u_div_one (.clk(clk), .num(in_dt_reg), .den(in_t1_reg), .quo(r1));
    psde_div u_div_two (.clk(clk), .num(in_dt_reg), .den(in_t2_reg), .quo(r2));

    psde_log u_log_one (.clk(clk), .ratio(r1), .ln_q(ln1));
    psde_exp u_exp_one (.clk(clk), .ratio(r1), .fac_q(ex1));
    psde_exp u_exp_two (.clk(clk), .ratio(r2), .fac_q(ex2));

    assign fac1 = side_reg[SIDE_LEN-1].log_one ? logd_reg[LOG_PAD-1] : 35'(ex1);

    psde_term u_term_one (.clk(clk), .amp(side_reg[SIDE_LEN-1].a1), .factor(fac1),
                          .term(term1));
    psde_term u_term_two (.clk(clk), .amp(side_reg[SIDE_LEN-1].a2), .factor(35'(ex2)),
                          .term(term2));

    // add the terms and clip to the output range
    always_ff @(posedge clk)
    begin
        logic signed [40:0] sum;
        sum = '0;
        if (tail_reg[TERM_LAT-1].use_terms)
        begin
            sum = 41'(term1);
            if (tail_reg[TERM_LAT-1].two)
            begin
                sum = sum + 41'(term2);
            end
        end
        zerr_reg <= tail_reg[TERM_LAT-1].zerr;
        if (sum > OUT_MAX)
        begin
            def_reg <= 40'(OUT_MAX);
            sat_reg <= 1'b1;
        end
        else if (sum < OUT_MIN)
        begin
            def_reg <= 40'(OUT_MIN);
            sat_reg <= 1'b1;
        end
        else
        begin
            def_reg <= 40'(sum);
            sat_reg <= 1'b0;
        end
    end

    assign done            = done_reg;
    assign deformation_mm  = def_reg;
    assign zero_time_error = zerr_reg;
    assign saturated       = sat_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && !busy && rst_n, PIPE_LAT))
        else $error("result strobe out of step with requests");

    a_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_time_error) |-> (deformation_mm == '0 && !saturated))
        else $error("zero relaxation time gave a nonzero result");

    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (deformation_mm == 40'(OUT_MAX) ||
                                 deformation_mm == 40'(OUT_MIN)))
        else $error("saturation flag without a clipped result");
`endif

endmodule
`default_nettype wire

### rtl/psde_div.sv
// Pipelined restoring divider: (num << 30) / den, one quotient bit per stage.
// Depends on psde_pkg.
`default_nettype none
module psde_div import psde_pkg::*;
(
    input  logic               clk,
    input  logic [31:0]        num,
    input  logic [31:0]        den,
    output logic [DIV_Q_W-1:0] quo
);

    typedef struct packed {
        logic [31:0]        rem;
        logic [31:0]        num;
        logic [31:0]        den;
        logic [DIV_Q_W-1:0] quo;
    } div_stage_t;

    div_stage_t src      [DIV_LAT];
    div_stage_t stg_next [DIV_LAT];
    div_stage_t stg_reg  [DIV_LAT];

    assign src[0] = '{rem: '0, num: num, den: den, quo: '0};

    genvar j;
    for (j = 0; j < DIV_LAT; j++)
    begin : g_stage
        if (j > 0)
        begin : g_link
            assign src[j] = stg_reg[j-1];
        end

        always_comb
        begin
            logic [32:0] trial;
            trial = {src[j].rem, src[j].num[31]};
            stg_next[j]     = src[j];
            stg_next[j].num = {src[j].num[30:0], 1'b0};
            if (trial >= {1'b0, src[j].den})
            begin
                stg_next[j].rem = 32'(trial - {1'b0, src[j].den});
                stg_next[j].quo = {src[j].quo[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                stg_next[j].rem = trial[31:0];
                stg_next[j].quo = {src[j].quo[DIV_Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            stg_reg[j] <= stg_next[j];
        end
    end

    assign quo = stg_reg[DIV_LAT-1].quo;

endmodule
`default_nettype wire

### rtl/psde_log.sv
// Pipelined ln(1 + r) for r in Q.30: normalize, 30 squaring stages, scale by ln 2.
// Depends on psde_pkg.
`default_nettype none
module psde_log import psde_pkg::*;
(
    input  logic               clk,
    input  logic [DIV_Q_W-1:0] ratio,
    output logic [34:0]        ln_q
);

    localparam int NRM_N = 6;

    typedef struct packed {
        logic [62:0] y;
        logic [5:0]  lz;
    } nrm_t;

    typedef struct packed {
        logic [30:0] m;
        logic [29:0] frac;
        logic [5:0]  ip;
    } sq_t;

    nrm_t nrm_src [NRM_N];
    nrm_t nrm_next[NRM_N];
    nrm_t nrm_reg [NRM_N];
    sq_t  sq_src  [QB];
    sq_t  sq_next [QB];
    sq_t  sq_reg  [QB];

    logic [59:0] pf_reg;
    logic [35:0] pi_reg;
    logic [34:0] ln_reg;

    assign nrm_src[0] = '{y: 63'(ratio) + 63'(ONE_Q), lz: '0};

    genvar j;
    for (j = 0; j < NRM_N; j++)
    begin : g_nrm
        localparam int SH = 32 >> j;
        if (j > 0)
        begin : g_link
            assign nrm_src[j] = nrm_reg[j-1];
        end

        // shift the leading one up to bit 62
        always_comb
        begin
            nrm_next[j] = nrm_src[j];
            if (nrm_src[j].y[62 -: SH] == '0)
            begin
                nrm_next[j].y  = nrm_src[j].y << SH;
                nrm_next[j].lz = nrm_src[j].lz + 6'(SH);
            end
        end

        always_ff @(posedge clk)
        begin
            nrm_reg[j] <= nrm_next[j];
        end
    end

    assign sq_src[0] = '{m:    nrm_reg[NRM_N-1].y[62:32],
                         frac: '0,
                         ip:   6'd32 - nrm_reg[NRM_N-1].lz};

    for (j = 0; j < QB; j++)
    begin : g_sq
        if (j > 0)
        begin : g_link
            assign sq_src[j] = sq_reg[j-1];
        end

        // square the mantissa; renormalize and emit one fraction bit of log2
        always_comb
        begin
            logic [61:0] sq;
            logic [31:0] t;
            sq = 62'(sq_src[j].m) * 62'(sq_src[j].m);
            t  = sq[61:30];
            sq_next[j] = sq_src[j];
            if (t[31])
            begin
                sq_next[j].m    = t[31:1];
                sq_next[j].frac = {sq_src[j].frac[28:0], 1'b1};
            end
            else
            begin
                sq_next[j].m    = t[30:0];
                sq_next[j].frac = {sq_src[j].frac[28:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[j] <= sq_next[j];
        end
    end

    always_ff @(posedge clk)
    begin
        pf_reg <= 60'(sq_reg[QB-1].frac) * 60'(LN2_Q);
        pi_reg <= 36'(sq_reg[QB-1].ip) * 36'(LN2_Q);
        ln_reg <= 35'(pi_reg + 36'(pf_reg[59:30]));
    end

    assign ln_q = ln_reg;

endmodule
`default_nettype wire

### rtl/psde_exp.sv
// Pipelined 1 - exp(-r) for r in Q.30: range reduction by ln 2, 13 Taylor terms.
// Depends on psde_pkg.
`default_nettype none
module psde_exp import psde_pkg::*;
(
    input  logic               clk,
    input  logic [DIV_Q_W-1:0] ratio,
    output logic [30:0]        fac_q
);

    localparam int KB     = 6;
    localparam int TERMS  = 13;
    localparam int TY_N   = 3 * TERMS;

    typedef struct packed {
        logic [34:0]   rem;
        logic [KB-1:0] k;
        logic          big;
    } kd_t;

    typedef struct packed {
        logic [60:0]        prod;
        logic [30:0]        x;
        logic [30:0]        est;
        logic [30:0]        term;
        logic signed [32:0] sum;
        logic [29:0]        g;
        logic [KB-1:0]      k;
        logic               big;
    } ty_t;

    kd_t kd_src [KB];
    kd_t kd_next[KB];
    kd_t kd_reg [KB];
    ty_t ty_next[TY_N];
    ty_t ty_reg [TY_N];
    ty_t ty_src [TERMS];

    logic [30:0] fac_reg;

    assign kd_src[0] = '{rem: ratio[34:0], k: '0, big: |ratio[DIV_Q_W-1:35]};

    genvar j;
    for (j = 0; j < KB; j++)
    begin : g_kd
        localparam int B = KB - 1 - j;
        localparam logic [34:0] DV = 35'(LN2_Q) << B;
        if (j > 0)
        begin : g_link
            assign kd_src[j] = kd_reg[j-1];
        end

        always_comb
        begin
            kd_next[j] = kd_src[j];
            if (kd_src[j].rem >= DV)
            begin
                kd_next[j].rem  = kd_src[j].rem - DV;
                kd_next[j].k[B] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            kd_reg[j] <= kd_next[j];
        end
    end

    assign ty_src[0] = '{prod: '0, x: '0, est: '0, term: ONE_Q,
                         sum:  33'(ONE_Q), g: kd_reg[KB-1].rem[29:0],
                         k:    kd_reg[KB-1].k, big: kd_reg[KB-1].big};

    for (j = 0; j < TERMS; j++)
    begin : g_term
        localparam int          N     = j + 1;
        localparam int          A     = 3 * j;
        localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);
        if (j > 0)
        begin : g_link
            assign ty_src[j] = ty_reg[A-1];
        end

        always_comb
        begin
            ty_next[A]      = ty_src[j];
            ty_next[A].prod = 61'(ty_src[j].term) * 61'(ty_src[j].g);
        end

        // quotient estimate by reciprocal, at most one low
        always_comb
        begin
            logic [63:0] p64;
            ty_next[A+1]   = ty_reg[A];
            ty_next[A+1].x = ty_reg[A].prod[60:30];
            p64 = 64'(ty_reg[A].prod[60:30]) * 64'(RECIP);
            ty_next[A+1].est = p64[62:32];
        end

        always_comb
        begin
            logic [34:0] rem;
            logic [30:0] q;
            rem = 35'(ty_reg[A+1].x) - 35'(ty_reg[A+1].est) * 35'(N);
            q   = (rem >= 35'(N)) ? ty_reg[A+1].est + 31'd1 : ty_reg[A+1].est;
            ty_next[A+2]      = ty_reg[A+1];
            ty_next[A+2].term = q;
            if (N % 2 == 1)
            begin
                ty_next[A+2].sum = ty_reg[A+1].sum - $signed({2'b00, q});
            end
            else
            begin
                ty_next[A+2].sum = ty_reg[A+1].sum + $signed({2'b00, q});
            end
        end

        always_ff @(posedge clk)
        begin
            ty_reg[A]   <= ty_next[A];
            ty_reg[A+1] <= ty_next[A+1];
            ty_reg[A+2] <= ty_next[A+2];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [31:0] s;
        logic [31:0] e;
        s = ty_reg[TY_N-1].sum[32] ? 32'd0 : ty_reg[TY_N-1].sum[31:0];
        e = s >> ty_reg[TY_N-1].k;
        if (ty_reg[TY_N-1].big)
        begin
            fac_reg <= ONE_Q;
        end
        else if (e > 32'(ONE_Q))
        begin
            fac_reg <= '0;
        end
        else
        begin
            fac_reg <= ONE_Q - e[30:0];
        end
    end

    assign fac_q = fac_reg;

endmodule
`default_nettype wire

### rtl/psde_term.sv
// One deformation term: amplitude times a Q.30 factor, rounded to the amplitude scale.
// Depends on psde_pkg.
`default_nettype none
module psde_term import psde_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] amp,
    input  logic [34:0]        factor,
    output logic signed [38:0] term
);

    logic               neg1_reg;
    logic [31:0]        mag_reg;
    logic [29:0]        f24_reg;
    logic               neg2_reg;
    logic [61:0]        prod_reg;
    logic signed [38:0] term_reg;

    always_ff @(posedge clk)
    begin
        logic [62:0] rnd;
        logic [37:0] q;
        neg1_reg <= amp[31];
        mag_reg  <= amp[31] ? (~amp + 32'd1) : amp;
        f24_reg  <= 30'((36'(factor) + 36'd32) >> 6);

        neg2_reg <= neg1_reg;
        prod_reg <= 62'(mag_reg) * 62'(f24_reg);

        // round half away from zero on the magnitude, then reapply the sign
        rnd = 63'(prod_reg) + 63'(24'h80_0000);
        q   = rnd[61:24];
        term_reg <= neg2_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    assign term = term_reg;

endmodule
`default_nettype wire
